>>> design/nncsa_pkg.sv
// Package for the nearest-neighbor crop/scale address generator.
// Holds the payload structs, field widths and configuration register indexes.
// No dependencies.
package nncsa_pkg;

    // Field widths
    localparam int DEST_W     = 10;
    localparam int EXT_W      = 14;
    localparam int PITCH_W    = 16;
    localparam int Q16_W      = 17;
    localparam int Q16_FRAC   = 16;
    localparam int SOFF_W     = 28;
    localparam int DOFF_W     = 22;
    localparam int BYTE_SHIFT = 2;

    // Configuration port
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 17;

    // Register reset values
    localparam logic [EXT_W-1:0]   IMAGE_WIDTH_RST  = 14'd1024;
    localparam logic [EXT_W-1:0]   IMAGE_HEIGHT_RST = 14'd1024;
    localparam logic [PITCH_W-1:0] ROW_PITCH_RST    = 16'd4096;
    localparam logic [Q16_W-1:0]   AREA_POS_RST     = 17'd0;
    localparam logic [Q16_W-1:0]   AREA_SIZE_RST    = 17'd65536;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_IMAGE_WIDTH  = 3'd0,
        CFG_IMAGE_HEIGHT = 3'd1,
        CFG_ROW_PITCH    = 3'd2,
        CFG_AREA_X       = 3'd3,
        CFG_AREA_Y       = 3'd4,
        CFG_AREA_W       = 3'd5,
        CFG_AREA_H       = 3'd6
    } t_cfg_idx;

    typedef struct packed {
        logic [DEST_W-1:0] dest_row;
        logic [DEST_W-1:0] dest_col;
    } t_in;

    typedef struct packed {
        logic [SOFF_W-1:0] source_offset;
        logic [DOFF_W-1:0] dest_offset;
        logic              clamped;
    } t_out;

endpackage

>>> design/nearest_neighbour_crop_scale_address.sv
// Nearest-neighbor crop/scale address generator, top level.
// Depends on nncsa_pkg.
//
//  channel  | direction | handshake                 | payload
//  ---------+-----------+---------------------------+----------------------------
//  in       | input     | i_in_valid / o_in_stall   | i_in_data  (t_in)
//  out      | output    | o_out_valid / i_out_stall | o_out_data (t_out)
//  cfg      | input     | i_cfg_valid / o_cfg_ready | i_cfg_index, i_cfg_data
//
//  One transaction per clock sustained while i_out_stall is low, through four
//  register stages (crop numerator, extent multiply, shift and clamp, offset multiply).
//  Reset clears all stage valid bits and loads the register reset values.
//  An output stall freezes occupied stages; empty stages keep filling, so
//  bubbles collapse and the input stalls only when every stage is full.
module nearest_neighbour_crop_scale_address #(
    parameter int TEX_WIDTH  = 1024,
    parameter int TEX_HEIGHT = 1024
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  nncsa_pkg::t_in                      i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output nncsa_pkg::t_out                     o_out_data,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [nncsa_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  logic [nncsa_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import nncsa_pkg::*;

    localparam int LOG_W  = $clog2(TEX_WIDTH);
    localparam int LOG_H  = $clog2(TEX_HEIGHT);
    localparam int MUL_W  = DEST_W + Q16_W;
    localparam int NUMC_W = ((Q16_W + LOG_W) > MUL_W ? (Q16_W + LOG_W) : MUL_W) + 1;
    localparam int NUMR_W = ((Q16_W + LOG_H) > MUL_W ? (Q16_W + LOG_H) : MUL_W) + 1;
    localparam int PRDC_W = NUMC_W + EXT_W;
    localparam int PRDR_W = NUMR_W + EXT_W;
    localparam int SRCC_W = PRDC_W - Q16_FRAC - LOG_W;
    localparam int SRCR_W = PRDR_W - Q16_FRAC - LOG_H;
    localparam int OFF_W  = EXT_W + PITCH_W + 1;

    // Configuration registers
    logic [EXT_W-1:0]   r_image_width;
    logic [EXT_W-1:0]   r_image_height;
    logic [PITCH_W-1:0] r_row_pitch;
    logic [Q16_W-1:0]   r_area_x;
    logic [Q16_W-1:0]   r_area_y;
    logic [Q16_W-1:0]   r_area_w;
    logic [Q16_W-1:0]   r_area_h;

    assign o_cfg_ready = 1'b1;

    // Take a register write; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_image_width  <= IMAGE_WIDTH_RST;
            r_image_height <= IMAGE_HEIGHT_RST;
            r_row_pitch    <= ROW_PITCH_RST;
            r_area_x       <= AREA_POS_RST;
            r_area_y       <= AREA_POS_RST;
            r_area_w       <= AREA_SIZE_RST;
            r_area_h       <= AREA_SIZE_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_IMAGE_WIDTH:  r_image_width  <= i_cfg_data[EXT_W-1:0];
                CFG_IMAGE_HEIGHT: r_image_height <= i_cfg_data[EXT_W-1:0];
                CFG_ROW_PITCH:    r_row_pitch    <= i_cfg_data[PITCH_W-1:0];
                CFG_AREA_X:       r_area_x       <= i_cfg_data[Q16_W-1:0];
                CFG_AREA_Y:       r_area_y       <= i_cfg_data[Q16_W-1:0];
                CFG_AREA_W:       r_area_w       <= i_cfg_data[Q16_W-1:0];
                CFG_AREA_H:       r_area_h       <= i_cfg_data[Q16_W-1:0];
                default: ;
            endcase
        end
    end

    // Stage load enables, chained back from the output
    logic w_en1, w_en2, w_en3, w_en4;
    logic r_v1, r_v2, r_v3, r_v4;

    assign w_en4      = !r_v4 || !i_out_stall;
    assign w_en3      = !r_v3 || w_en4;
    assign w_en2      = !r_v2 || w_en3;
    assign w_en1      = !r_v1 || w_en2;
    assign o_in_stall = !w_en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (w_en1) r_v1 <= i_in_valid;
            if (w_en2) r_v2 <= r_v1;
            if (w_en3) r_v3 <= r_v2;
            if (w_en4) r_v4 <= r_v3;
        end
    end

    // Stage 1: crop numerators pos * tex + dest * size, destination offset
    logic [MUL_W-1:0]  w_mul_r, w_mul_c;
    logic [NUMR_W-1:0] n_num_r, r_num_r;
    logic [NUMC_W-1:0] n_num_c, r_num_c;
    logic [DOFF_W-1:0] n_doff, r_doff1, r_doff2, r_doff3;

    assign w_mul_r = MUL_W'(i_in_data.dest_row) * MUL_W'(r_area_h);
    assign w_mul_c = MUL_W'(i_in_data.dest_col) * MUL_W'(r_area_w);
    assign n_num_r = (NUMR_W'(r_area_y) << LOG_H) + NUMR_W'(w_mul_r);
    assign n_num_c = (NUMC_W'(r_area_x) << LOG_W) + NUMC_W'(w_mul_c);
    assign n_doff  = ((DOFF_W'(i_in_data.dest_row) << LOG_W)
                     + DOFF_W'(i_in_data.dest_col)) << BYTE_SHIFT;

    always_ff @(posedge i_clk) begin
        if (w_en1) begin
            r_num_r <= n_num_r;
            r_num_c <= n_num_c;
            r_doff1 <= n_doff;
        end
    end

    // Stage 2: scale by the image extent
    logic [PRDR_W-1:0] n_prd_r, r_prd_r;
    logic [PRDC_W-1:0] n_prd_c, r_prd_c;

    assign n_prd_r = PRDR_W'(r_image_height) * PRDR_W'(r_num_r);
    assign n_prd_c = PRDC_W'(r_image_width) * PRDC_W'(r_num_c);

    always_ff @(posedge i_clk) begin
        if (w_en2) begin
            r_prd_r <= n_prd_r;
            r_prd_c <= n_prd_c;
            r_doff2 <= r_doff1;
        end
    end

    // Stage 3: drop the fraction, clamp to the last row and column (to zero for a zero extent)
    logic [SRCR_W-1:0] w_src_r;
    logic [SRCC_W-1:0] w_src_c;
    logic [EXT_W-1:0]  n_srow, n_scol, r_srow, r_scol;
    logic              n_clamp_r, n_clamp_c, r_clamp3;

    assign w_src_r = r_prd_r[PRDR_W-1:Q16_FRAC+LOG_H];
    assign w_src_c = r_prd_c[PRDC_W-1:Q16_FRAC+LOG_W];

    always_comb begin
        n_clamp_r = 1'b0;
        n_srow    = w_src_r[EXT_W-1:0];
        priority if (r_image_height == '0) begin
            n_clamp_r = 1'b1;
            n_srow    = '0;
        end else if (w_src_r >= SRCR_W'(r_image_height)) begin
            n_clamp_r = 1'b1;
            n_srow    = r_image_height - EXT_W'(1);
        end
        n_clamp_c = 1'b0;
        n_scol    = w_src_c[EXT_W-1:0];
        priority if (r_image_width == '0) begin
            n_clamp_c = 1'b1;
            n_scol    = '0;
        end else if (w_src_c >= SRCC_W'(r_image_width)) begin
            n_clamp_c = 1'b1;
            n_scol    = r_image_width - EXT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en3) begin
            r_srow   <= n_srow;
            r_scol   <= n_scol;
            r_clamp3 <= n_clamp_r || n_clamp_c;
            r_doff3  <= r_doff2;
        end
    end

    // Stage 4: source byte offset, held in the output register
    logic [OFF_W-1:0] w_soff;
    t_out             n_out, r_out;

    assign w_soff = OFF_W'(r_srow) * OFF_W'(r_row_pitch)
                  + (OFF_W'(r_scol) << BYTE_SHIFT);

    always_comb begin
        n_out.source_offset = w_soff[SOFF_W-1:0];
        n_out.dest_offset   = r_doff3;
        n_out.clamped       = r_clamp3;
    end

    always_ff @(posedge i_clk) begin
        if (w_en4) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_v4;
    assign o_out_data  = r_out;

    // An empty output stage never holds back the input
    a_no_stall_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_valid |-> !o_in_stall)
        else $error("input stalled with empty output stage");

    // An accepted transaction lands in stage 1
    a_accept_lands: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && !o_in_stall) |=> r_v1)
        else $error("accepted transaction lost at stage 1");

    // A blocked stage 1 keeps its contents
    a_stage1_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && !w_en2) |=> (r_v1 && $stable(r_num_r) && $stable(r_num_c)
                              && $stable(r_doff1)))
        else $error("stage 1 changed while blocked");

    // A blocked stage 3 keeps its contents
    a_stage3_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v3 && !w_en4) |=> (r_v3 && $stable(r_srow) && $stable(r_scol)
                              && $stable(r_clamp3)))
        else $error("stage 3 changed while blocked");

endmodule
